FILE: src/interval_arith_alu_macros.svh
// assertion macros shared by the checker of the interval alu
`ifndef INTERVAL_ARITH_ALU_MACROS_SVH
`define INTERVAL_ARITH_ALU_MACROS_SVH

// implication checked outside reset
`define IAA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interval alu assertion failed");

// next-cycle implication checked also during reset
`define IAA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("interval alu assertion failed");

`endif

FILE: src/iaa_pkg.sv
// types, codes and helper functions of the interval alu
package iaa_pkg;

    localparam int DW    = 32;
    localparam int WW    = 2 * DW + 2;
    localparam int NCELL = DW;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                  req_type;
        logic signed [DW-1:0] a_lower;
        logic signed [DW-1:0] a_upper;
        logic signed [DW-1:0] b_lower;
        logic signed [DW-1:0] b_upper;
    } t_req;

    typedef struct packed {
        logic signed [DW-1:0] res_lower;
        logic signed [DW-1:0] res_upper;
        t_status              status;
    } t_res;

    // payload that moves through the divider cells
    typedef struct packed {
        t_op                 op;
        t_status             status;
        logic [3:0][WW-1:0]  val;
        logic [3:0][DW-1:0]  quo;
        logic [3:0][DW-1:0]  rem;
        logic [3:0][DW-1:0]  dvd;
        logic [1:0][DW-1:0]  dsr;
        logic [3:0]          neg;
    } t_pipe;

    typedef struct packed {
        t_status             status;
        logic signed [WW-1:0] lo;
        logic signed [WW-1:0] hi;
    } t_mm;

    function automatic logic signed [WW-1:0] sx(input logic signed [DW-1:0] x);
        return {{(WW-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    // saturate to the data width, msb of result flags saturation
    function automatic logic [DW:0] clamp(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] vmin;
        logic signed [WW-1:0] vmax;
        vmin = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};
        vmax = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        if (v < vmin) begin
            return {1'b1, 1'b1, {(DW-1){1'b0}}};
        end else if (v > vmax) begin
            return {1'b1, 1'b0, {(DW-1){1'b1}}};
        end
        return {1'b0, v[DW-1:0]};
    endfunction

endpackage

FILE: src/iaa_front.sv
// entry stage: range checks, add/sub sums, corner products, divider setup
module iaa_front
    import iaa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_v,
    output t_pipe o_data
);

    logic                 r_v;
    t_pipe                r_d;
    t_pipe                n_d;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] bi;
    logic signed [DW-1:0] x [4];
    logic signed [DW-1:0] y [4];
    logic signed [2*DW-1:0] p [4];
    logic signed [WW-1:0] lo;
    logic signed [WW-1:0] hi;

    assign ai = i_req.a_upper - DW'(1);
    assign bi = i_req.b_upper - DW'(1);

    always_comb begin
        x[0] = i_req.a_lower; y[0] = i_req.b_lower;
        x[1] = i_req.a_lower; y[1] = bi;
        x[2] = ai;            y[2] = i_req.b_lower;
        x[3] = ai;            y[3] = bi;
        for (int k = 0; k < 4; k++) begin
            p[k] = x[k] * y[k];
        end
    end

    always_comb begin
        if (i_req.req_type == OP_SUB) begin
            lo = sx(i_req.a_lower) - sx(bi);
            hi = sx(ai) - sx(i_req.b_lower);
        end else begin
            lo = sx(i_req.a_lower) + sx(i_req.b_lower);
            hi = sx(ai) + sx(bi);
        end
    end

    always_comb begin
        n_d        = '0;
        n_d.op     = i_req.req_type;
        n_d.status = ST_OK;
        if (i_req.a_lower >= i_req.a_upper || i_req.b_lower >= i_req.b_upper) begin
            n_d.status = ST_INVALID;
        end else if (i_req.req_type == OP_DIV && i_req.b_lower <= 0 && i_req.b_upper > 0) begin
            n_d.status = ST_DIVZERO;
        end
        for (int k = 0; k < 4; k++) begin
            if (i_req.req_type == OP_MUL) begin
                n_d.val[k] = {{2{p[k][2*DW-1]}}, p[k]};
            end else begin
                n_d.val[k] = k[0] ? hi : lo;
            end
            n_d.dvd[k] = mag(x[k]);
            n_d.neg[k] = x[k][DW-1] ^ y[k][DW-1];
        end
        n_d.dsr[0] = mag(i_req.b_lower);
        n_d.dsr[1] = mag(bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_data = r_d;

endmodule

FILE: src/iaa_cell.sv
// one divider cell: one restoring quotient bit for each of the four quotients
module iaa_cell
    import iaa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_v,
    input  t_pipe i_data,
    output logic  o_v,
    output t_pipe o_data
);

    logic        r_v;
    t_pipe       r_d;
    t_pipe       n_d;
    logic [DW:0] tr [4];
    logic [DW:0] dv [4];

    always_comb begin
        n_d = i_data;
        for (int k = 0; k < 4; k++) begin
            tr[k] = {i_data.rem[k], i_data.dvd[k][DW-1]};
            dv[k] = {1'b0, i_data.dsr[k % 2]};
            if (i_data.op == OP_DIV) begin
                n_d.dvd[k] = {i_data.dvd[k][DW-2:0], 1'b0};
                if (tr[k] >= dv[k]) begin
                    n_d.rem[k] = DW'(tr[k] - dv[k]);
                    n_d.quo[k] = {i_data.quo[k][DW-2:0], 1'b1};
                end else begin
                    n_d.rem[k] = tr[k][DW-1:0];
                    n_d.quo[k] = {i_data.quo[k][DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_v    = r_v;
    assign o_data = r_d;

endmodule

FILE: src/iaa_back.sv
// exit stages: quotient signs, min and max of the corners, bump and saturation
module iaa_back
    import iaa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_en,
    input  logic       i_v,
    input  t_pipe      i_data,
    output logic [2:0] o_v,
    output t_res       o_res
);

    logic [2:0]           r_v;
    t_status              r_st_a;
    logic [3:0][WW-1:0]   r_val;
    logic [3:0][WW-1:0]   n_val;
    t_mm                  r_mm;
    t_mm                  n_mm;
    t_res                 r_res;
    t_res                 n_res;
    logic signed [WW-1:0] c [4];
    logic signed [WW-1:0] lo01, lo23, hi01, hi23;
    logic signed [WW-1:0] hp;
    logic [DW:0]          cl;
    logic [DW:0]          ch;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_data.op == OP_DIV) begin
                n_val[k] = i_data.neg[k] ? WW'(-{{(WW-DW){1'b0}}, i_data.quo[k]})
                                         : {{(WW-DW){1'b0}}, i_data.quo[k]};
            end else begin
                n_val[k] = i_data.val[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c[k] = $signed(r_val[k]);
        end
        lo01 = (c[1] < c[0]) ? c[1] : c[0];
        hi01 = (c[1] > c[0]) ? c[1] : c[0];
        lo23 = (c[3] < c[2]) ? c[3] : c[2];
        hi23 = (c[3] > c[2]) ? c[3] : c[2];
        n_mm.status = r_st_a;
        n_mm.lo     = (lo23 < lo01) ? lo23 : lo01;
        n_mm.hi     = (hi23 > hi01) ? hi23 : hi01;
    end

    always_comb begin
        hp = r_mm.hi + WW'(1);
        cl = clamp(r_mm.lo);
        ch = clamp(hp);
        n_res = '0;
        n_res.status = r_mm.status;
        if (r_mm.status == ST_OK) begin
            n_res.res_lower = cl[DW-1:0];
            n_res.res_upper = ch[DW-1:0];
            if (cl[DW] || ch[DW]) begin
                n_res.status = ST_SAT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_en[0]) r_v[0] <= i_v;
            if (i_en[1]) r_v[1] <= r_v[0];
            if (i_en[2]) r_v[2] <= r_v[1];
        end
        if (i_en[0]) begin
            r_val  <= n_val;
            r_st_a <= i_data.status;
        end
        if (i_en[1]) begin
            r_mm <= n_mm;
        end
        if (i_en[2]) begin
            r_res <= n_res;
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;

endmodule

FILE: src/interval_arith_alu.sv
// top level of the interval alu: entry stage, divider cell chain, exit stages
//
// channel   direction  valid     stall     payload
// request   in         i_valid   o_stall   i_req (t_req)
// result    out        o_valid   i_stall   o_res (t_res)
//
// one transaction per cycle while nothing stalls; every operation passes NCELL + 4 = 36
// stages, among them the chain of 32 divider cells, one quotient bit per cell.
// each stage moves whenever the stage after it is empty or moving, so
// bubbles close up; once every stage is full, i_stall shows on o_stall in the same cycle.
// reset clears the stage valid bits only.
module interval_arith_alu
    import iaa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam int NST = NCELL + 4;

    logic [NST-1:0] v;
    logic [NST:0]   en;
    t_pipe          d [NCELL+1];

    assign en[NST] = !i_stall;
    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_en
            assign en[g] = !v[g] || en[g+1];
        end
    endgenerate

    iaa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_v     (v[0]),
        .o_data  (d[0])
    );

    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            iaa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en[g+1]),
                .i_v     (v[g]),
                .i_data  (d[g]),
                .o_v     (v[g+1]),
                .o_data  (d[g+1])
            );
        end
    endgenerate

    iaa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[NST-1:NST-3]),
        .i_v     (v[NCELL]),
        .i_data  (d[NCELL]),
        .o_v     (v[NST-1:NST-3]),
        .o_res   (o_res)
    );

    assign o_stall = !en[0];
    assign o_valid = v[NST-1];

endmodule

FILE: src/iaa_chk.sv
// port checker of the interval alu and its bind
`include "interval_arith_alu_macros.svh"

module iaa_chk
    import iaa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_res o_res
);

    // error results carry empty bounds
    `IAA_ASSERT_IMP(a_err_zero, o_valid && (o_res.status == ST_INVALID || o_res.status == ST_DIVZERO), o_res.res_lower == 0 && o_res.res_upper == 0)

    // saturation leaves at least one bound at a limit
    `IAA_ASSERT_IMP(a_sat_limit, o_valid && o_res.status == ST_SAT, o_res.res_lower == {1'b1, {(DW-1){1'b0}}} || o_res.res_lower == {1'b0, {(DW-1){1'b1}}} || o_res.res_upper == {1'b1, {(DW-1){1'b0}}} || o_res.res_upper == {1'b0, {(DW-1){1'b1}}})

    // nothing comes out right after reset
    `IAA_ASSERT_NXT(a_rst_idle, !i_rst_n, !o_valid)

    // a stalled result holds
    `IAA_ASSERT_IMP(a_out_hold, $past(o_valid && i_stall && i_rst_n), o_valid && $stable(o_res))

endmodule

bind interval_arith_alu iaa_chk u_iaa_chk (.*);
